// ----- rtl/lbc_pkg.sv -----
package lbc_pkg;

    localparam int N_ENTRIES   = 256;
    localparam int IDX_W       = $clog2(N_ENTRIES);
    localparam int EIU_W       = IDX_W + 1;
    localparam int BLOCK_WORDS = 32;
    localparam int WIDX_W      = $clog2(BLOCK_WORDS);
    localparam int WPOS_W      = WIDX_W + 1;
    localparam int ADDR_W      = IDX_W + WIDX_W;
    localparam int CNT_W       = 32;
    localparam int DISK_W      = 4;
    localparam int BLK_W       = 8;
    localparam int WORD_W      = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 9;
    localparam int S_DATA_W    = 80;
    localparam int M_DATA_W    = 136;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_DIS  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd1;

    typedef struct packed {
        logic             act;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] min_cnt;
        logic [IDX_W-1:0] min_idx;
    } search_t;

    typedef struct packed {
        logic              we;
        logic              ins;
        logic [IDX_W-1:0]  idx;
        logic [DISK_W-1:0] disk;
        logic [BLK_W-1:0]  blk;
    } wr_cmd_t;

endpackage

// ----- rtl/lfu_block_cache_unit.sv -----
// Lookup hit: the search passes all 256 cells, then the block is sent one word
// at a time. Miss or duplicate: the result follows the search. Final
// insert/update word: the search, then a copy of the 32-word block into the store.
// Non-final words: taken in idle, no search. Disabled, mode 3 or empty-cache
// lookups: result with no search. One request at a time. Reset is synchronous,
// active low: cache empty, counters zero, disabled, 256 entries in use.
module lfu_block_cache_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lbc_pkg::S_DATA_W-1:0]      s_tdata,  // mode, disk, block, data_in
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lbc_pkg::M_DATA_W-1:0]      m_tdata,  // status, data_out, hit_count, query_count
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lbc_pkg::CFG_W-1:0]         cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_CPRD  = 4'd2;
    localparam logic [3:0] S_CPWR  = 4'd3;
    localparam logic [3:0] S_RESP  = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_SEND  = 4'd6;

    logic [3:0]                    state_reg;
    logic                          enable_reg;
    logic [lbc_pkg::EIU_W-1:0]     eiu_reg;
    logic [lbc_pkg::EIU_W-1:0]     occ_reg;
    logic [lbc_pkg::CNT_W-1:0]     hits_reg;
    logic [lbc_pkg::CNT_W-1:0]     queries_reg;
    logic [lbc_pkg::WPOS_W-1:0]    wpos_reg;
    logic [lbc_pkg::WPOS_W-1:0]    fill_reg;
    logic [1:0]                    op_reg;
    logic [1:0]                    resp_reg;
    logic [lbc_pkg::DISK_W-1:0]    key_disk_reg;
    logic [lbc_pkg::BLK_W-1:0]     key_blk_reg;
    logic [lbc_pkg::IDX_W-1:0]     slot_reg;
    logic [lbc_pkg::WIDX_W-1:0]    k_reg;
    logic                          start_reg;
    lbc_pkg::wr_cmd_t              cmd_reg;

    logic [lbc_pkg::WORD_W-1:0]    inc_mem [0:lbc_pkg::BLOCK_WORDS-1];
    logic [lbc_pkg::WORD_W-1:0]    bs_mem  [0:(1 << lbc_pkg::ADDR_W)-1];
    logic [lbc_pkg::WORD_W-1:0]    inc_rdata_reg;
    logic [lbc_pkg::WORD_W-1:0]    bs_rdata_reg;
    logic [lbc_pkg::ADDR_W-1:0]    bs_addr;

    logic                          m_tvalid_reg;
    logic [1:0]                    o_status_reg;
    logic [lbc_pkg::WORD_W-1:0]    o_data_reg;
    logic                          o_last_reg;
    logic [lbc_pkg::CNT_W-1:0]     o_hits_reg;
    logic [lbc_pkg::CNT_W-1:0]     o_queries_reg;

    logic [1:0]                    in_mode;
    logic [lbc_pkg::DISK_W-1:0]    in_disk;
    logic [lbc_pkg::BLK_W-1:0]     in_blk;
    logic [lbc_pkg::WORD_W-1:0]    in_data;
    logic                          s_acc;
    logic                          out_free;
    logic                          out_load;
    logic                          cfg_clr;
    logic [lbc_pkg::CFG_W-1:0]     eiu_clamp;
    lbc_pkg::search_t              chain_in;
    lbc_pkg::search_t              chain_out;
    logic                          full;

    assign in_mode  = s_tdata[1:0];
    assign in_disk  = s_tdata[5:2];
    assign in_blk   = s_tdata[13:6];
    assign in_data  = s_tdata[77:14];
    assign s_tready = state_reg == S_IDLE;
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = out_free && (state_reg == S_RESP || state_reg == S_SEND);
    assign full     = occ_reg >= eiu_reg;
    assign bs_addr  = {slot_reg, k_reg};

    assign cfg_clr = cfg_we && ((cfg_index == lbc_pkg::REG_ENABLE && !cfg_data[0])
                                || cfg_index == lbc_pkg::REG_ENTRIES);

    always_comb begin
        if (cfg_data < lbc_pkg::CFG_W'(2)) begin
            eiu_clamp = lbc_pkg::CFG_W'(2);
        end else if (cfg_data > lbc_pkg::CFG_W'(lbc_pkg::N_ENTRIES)) begin
            eiu_clamp = lbc_pkg::CFG_W'(lbc_pkg::N_ENTRIES);
        end else begin
            eiu_clamp = cfg_data;
        end
    end

    always_comb begin
        chain_in          = '0;
        chain_in.act      = start_reg;
        chain_in.min_cnt  = lbc_pkg::CNT_MAX;
    end

    lbc_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eiu       (eiu_reg),
        .key_disk  (key_disk_reg),
        .key_blk   (key_blk_reg),
        .clr       (cfg_clr),
        .cmd       (cmd_reg),
        .chain_in  (chain_in),
        .chain_out (chain_out)
    );

    always_ff @(posedge aclk) begin
        inc_rdata_reg <= inc_mem[k_reg];
        bs_rdata_reg  <= bs_mem[bs_addr];
        if (s_acc && enable_reg && (in_mode == lbc_pkg::MODE_INSERT
                || in_mode == lbc_pkg::MODE_UPDATE)
                && wpos_reg < lbc_pkg::WPOS_W'(lbc_pkg::BLOCK_WORDS)) begin
            inc_mem[wpos_reg[lbc_pkg::WIDX_W-1:0]] <= in_data;
        end
        if (state_reg == S_CPWR) begin
            bs_mem[bs_addr] <= ({1'b0, k_reg} < fill_reg) ? inc_rdata_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            enable_reg   <= 1'b0;
            eiu_reg      <= lbc_pkg::EIU_W'(lbc_pkg::N_ENTRIES);
            occ_reg      <= '0;
            hits_reg     <= '0;
            queries_reg  <= '0;
            wpos_reg     <= '0;
            start_reg    <= 1'b0;
            cmd_reg.we   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            start_reg  <= 1'b0;
            cmd_reg.we <= 1'b0;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we && cfg_index == lbc_pkg::REG_ENABLE) begin
                enable_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == lbc_pkg::REG_ENTRIES) begin
                eiu_reg <= lbc_pkg::EIU_W'(eiu_clamp);
            end
            if (cfg_clr) begin
                occ_reg     <= '0;
                hits_reg    <= '0;
                queries_reg <= '0;
                wpos_reg    <= '0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        key_disk_reg <= in_disk;
                        key_blk_reg  <= in_blk;
                        op_reg       <= in_mode;
                        if (in_mode == lbc_pkg::MODE_INSERT
                                || in_mode == lbc_pkg::MODE_UPDATE) begin
                            if (!enable_reg) begin
                                if (s_tlast) begin
                                    resp_reg  <= lbc_pkg::ST_DIS;
                                    state_reg <= S_RESP;
                                end
                            end else begin
                                if (wpos_reg < lbc_pkg::WPOS_W'(lbc_pkg::BLOCK_WORDS)) begin
                                    wpos_reg <= wpos_reg + 1'b1;
                                end
                                if (s_tlast) begin
                                    start_reg <= 1'b1;
                                    state_reg <= S_SRCH;
                                end
                            end
                        end else if (!enable_reg) begin
                            resp_reg  <= lbc_pkg::ST_DIS;
                            state_reg <= S_RESP;
                        end else if (in_mode != lbc_pkg::MODE_LOOKUP || occ_reg == '0) begin
                            resp_reg  <= lbc_pkg::ST_MISS;
                            state_reg <= S_RESP;
                        end else begin
                            if (queries_reg != lbc_pkg::CNT_MAX) begin
                                queries_reg <= queries_reg + 1'b1;
                            end
                            start_reg <= 1'b1;
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    if (chain_out.act) begin
                        k_reg <= '0;
                        if (op_reg == lbc_pkg::MODE_LOOKUP) begin
                            if (chain_out.hit) begin
                                if (hits_reg != lbc_pkg::CNT_MAX) begin
                                    hits_reg <= hits_reg + 1'b1;
                                end
                                slot_reg  <= chain_out.hit_idx;
                                state_reg <= S_RD;
                            end else begin
                                resp_reg  <= lbc_pkg::ST_MISS;
                                state_reg <= S_RESP;
                            end
                        end else begin
                            fill_reg     <= wpos_reg;
                            wpos_reg     <= '0;
                            cmd_reg.disk <= key_disk_reg;
                            cmd_reg.blk  <= key_blk_reg;
                            if (op_reg == lbc_pkg::MODE_INSERT) begin
                                if (chain_out.hit) begin
                                    resp_reg  <= lbc_pkg::ST_DUP;
                                    state_reg <= S_RESP;
                                end else begin
                                    slot_reg    <= full ? chain_out.min_idx : chain_out.free_idx;
                                    cmd_reg.idx <= full ? chain_out.min_idx : chain_out.free_idx;
                                    cmd_reg.we  <= 1'b1;
                                    cmd_reg.ins <= 1'b1;
                                    if (!full) begin
                                        occ_reg <= occ_reg + 1'b1;
                                    end
                                    state_reg <= S_CPRD;
                                end
                            end else if (chain_out.hit) begin
                                slot_reg    <= chain_out.hit_idx;
                                cmd_reg.idx <= chain_out.hit_idx;
                                cmd_reg.we  <= 1'b1;
                                cmd_reg.ins <= 1'b0;
                                state_reg   <= S_CPRD;
                            end else begin
                                resp_reg  <= lbc_pkg::ST_MISS;
                                state_reg <= S_RESP;
                            end
                        end
                    end
                end
                S_CPRD: begin
                    state_reg <= S_CPWR;
                end
                S_CPWR: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == '1) begin
                        resp_reg  <= lbc_pkg::ST_OK;
                        state_reg <= S_RESP;
                    end else begin
                        state_reg <= S_CPRD;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        o_status_reg  <= resp_reg;
                        o_data_reg    <= '0;
                        o_last_reg    <= 1'b1;
                        o_hits_reg    <= hits_reg;
                        o_queries_reg <= queries_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                S_RD: begin
                    state_reg <= S_SEND;
                end
                S_SEND: begin
                    if (out_free) begin
                        o_status_reg  <= lbc_pkg::ST_OK;
                        o_data_reg    <= bs_rdata_reg;
                        o_last_reg    <= k_reg == '1;
                        o_hits_reg    <= hits_reg;
                        o_queries_reg <= queries_reg;
                        k_reg         <= k_reg + 1'b1;
                        state_reg     <= (k_reg == '1) ? S_IDLE : S_RD;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {6'd0, o_queries_reg, o_hits_reg, o_data_reg, o_status_reg};

endmodule

// ----- rtl/lbc_cell.sv -----
module lbc_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [lbc_pkg::IDX_W-1:0] cell_idx,
    input  logic [lbc_pkg::EIU_W-1:0] eiu,
    input  logic [lbc_pkg::DISK_W-1:0] key_disk,
    input  logic [lbc_pkg::BLK_W-1:0] key_blk,
    input  logic                      clr,
    input  lbc_pkg::wr_cmd_t          cmd,
    input  lbc_pkg::search_t          rec_in,
    output lbc_pkg::search_t          rec_out
);

    logic                        valid_reg;
    logic [lbc_pkg::DISK_W-1:0]  disk_reg;
    logic [lbc_pkg::BLK_W-1:0]   blk_reg;
    logic [lbc_pkg::CNT_W-1:0]   cnt_reg;
    lbc_pkg::search_t            rec_reg;
    lbc_pkg::search_t            rec_next;
    logic                        in_use;

    assign in_use = {1'b0, cell_idx} < eiu;

    always_comb begin
        rec_next = rec_in;
        if (rec_in.act && in_use) begin
            if (valid_reg && disk_reg == key_disk && blk_reg == key_blk && !rec_in.hit) begin
                rec_next.hit     = 1'b1;
                rec_next.hit_idx = cell_idx;
            end
            if (!valid_reg && !rec_in.free) begin
                rec_next.free     = 1'b1;
                rec_next.free_idx = cell_idx;
            end
            if (valid_reg && cnt_reg < rec_in.min_cnt) begin
                rec_next.min_cnt = cnt_reg;
                rec_next.min_idx = cell_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            rec_reg.act <= 1'b0;
        end else begin
            rec_reg <= rec_next;
            if (clr) begin
                valid_reg <= 1'b0;
            end else if (cmd.we && cmd.idx == cell_idx) begin
                if (cmd.ins) begin
                    valid_reg <= 1'b1;
                    disk_reg  <= cmd.disk;
                    blk_reg   <= cmd.blk;
                    cnt_reg   <= lbc_pkg::CNT_W'(1);
                end else if (cnt_reg != lbc_pkg::CNT_MAX) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign rec_out = rec_reg;

endmodule

// ----- rtl/lbc_chain.sv -----
module lbc_chain (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [lbc_pkg::EIU_W-1:0]  eiu,
    input  logic [lbc_pkg::DISK_W-1:0] key_disk,
    input  logic [lbc_pkg::BLK_W-1:0]  key_blk,
    input  logic                       clr,
    input  lbc_pkg::wr_cmd_t           cmd,
    input  lbc_pkg::search_t           chain_in,
    output lbc_pkg::search_t           chain_out
);

    lbc_pkg::search_t rec [0:lbc_pkg::N_ENTRIES];

    assign rec[0] = chain_in;

    for (genvar i = 0; i < lbc_pkg::N_ENTRIES; i++) begin : g_cell
        lbc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (lbc_pkg::IDX_W'(i)),
            .eiu      (eiu),
            .key_disk (key_disk),
            .key_blk  (key_blk),
            .clr      (clr),
            .cmd      (cmd),
            .rec_in   (rec[i]),
            .rec_out  (rec[i+1])
        );
    end

    assign chain_out = rec[lbc_pkg::N_ENTRIES];

endmodule

// ----- rtl/lbc_checker.sv -----
module lbc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lbc_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tlast
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != lbc_pkg::ST_OK |-> m_tlast && m_tdata[65:2] == '0)
        else $error("failed request not a single zero word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[97:66] <= m_tdata[129:98])
        else $error("hit count above query count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid || m_tdata[1:0] == lbc_pkg::ST_OK)
        else $error("block stream broken");

endmodule

bind lfu_block_cache_unit lbc_checker u_lbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
